FILE: rtl/trm_pkg.sv
`default_nettype none
package trm_pkg;

	// default size of the first-run store
	localparam int FIRST_RUN_DEPTH = 32;
	// entries of the command queue and of the result queue
	localparam int QUEUE_DEPTH = 2;

	localparam int WORD_W = 64;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              from_second_run;
		logic              final_item;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] merged_word;
		logic              item_done;
		logic              merge_done;
		logic              dropped;
	} result_t;

	// command kinds handed from the front to the back
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_MERGE = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              kind;
		logic              fin;
	} cmd_t;

endpackage
`default_nettype wire

FILE: rtl/trm_fifo.sv
`default_nettype none
module trm_fifo #(
	parameter type T     = logic [7:0],
	parameter int  DEPTH = trm_pkg::QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire T     din,
	input  wire logic pop,
	output logic      empty,
	output T          dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T                entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/trm_front.sv
`default_nettype none
module trm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire trm_pkg::item_t item,
	input  wire logic          cmd_pop,
	output logic               cmd_empty,
	output trm_pkg::cmd_t      cmd
);

	trm_pkg::cmd_t cmd_in;

	// classify: first-run words are stored, second-run words drive a merge
	always_comb begin
		cmd_in.word = item.word;
		cmd_in.kind = item.from_second_run ? trm_pkg::CMD_MERGE : trm_pkg::CMD_STORE;
		cmd_in.fin  = item.final_item;
	end

	trm_fifo #(
		.T     (trm_pkg::cmd_t),
		.DEPTH (trm_pkg::QUEUE_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.din   (cmd_in),
		.pop   (cmd_pop),
		.empty (cmd_empty),
		.dout  (cmd)
	);

endmodule
`default_nettype wire

FILE: rtl/trm_back.sv
`default_nettype none
module trm_back #(
	parameter int FIRST_RUN_DEPTH = trm_pkg::FIRST_RUN_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_empty,
	output logic               cmd_pop,
	input  wire trm_pkg::cmd_t cmd,
	input  wire logic          res_full,
	output logic               res_push,
	output trm_pkg::result_t   res
);

	localparam int AW = (FIRST_RUN_DEPTH > 1) ? $clog2(FIRST_RUN_DEPTH) : 1;
	localparam int CW = $clog2(FIRST_RUN_DEPTH + 1);
	localparam int WW = trm_pkg::WORD_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MERGE = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]    state_q, state_next;
	logic [CW-1:0] rp_q, rp_next;
	logic [CW-1:0] wc_q, wc_next;
	logic          ovf_q, ovf_next;
	logic [WW-1:0] cur_word_q;
	logic          cur_fin_q;

	logic [WW-1:0] store_mem [FIRST_RUN_DEPTH];
	logic [WW-1:0] rd_q;
	logic [AW-1:0] ra;
	logic          we;
	logic          has_stored;
	logic          last_stored;
	logic          load_cur;

	assign has_stored  = (rp_q < wc_q);
	assign last_stored = ((rp_q + 1'b1) == wc_q);
	assign ra = (rp_next < CW'(FIRST_RUN_DEPTH)) ? rp_next[AW-1:0] : '0;

	// store: read data always tracks the entry at the next read pointer
	always_ff @(posedge clk) begin
		if (we) begin
			store_mem[wc_q[AW-1:0]] <= cmd.word;
		end
		if (we && (wc_q == rp_next)) begin
			rd_q <= cmd.word;
		end else begin
			rd_q <= store_mem[ra];
		end
	end

	always_comb begin
		state_next      = state_q;
		rp_next         = rp_q;
		wc_next         = wc_q;
		ovf_next        = ovf_q;
		cmd_pop         = 1'b0;
		load_cur        = 1'b0;
		we              = 1'b0;
		res_push        = 1'b0;
		res.merged_word = rd_q;
		res.item_done   = 1'b0;
		res.merge_done  = 1'b0;
		res.dropped     = ovf_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop  = 1'b1;
					load_cur = 1'b1;
					if (cmd.kind == trm_pkg::CMD_STORE) begin
						if (wc_q < CW'(FIRST_RUN_DEPTH)) begin
							we      = 1'b1;
							wc_next = wc_q + 1'b1;
						end else begin
							ovf_next = 1'b1;
						end
						state_next = cmd.fin ? ST_FLUSH : ST_IDLE;
					end else begin
						state_next = ST_MERGE;
					end
				end
			end
			ST_MERGE: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (has_stored && (rd_q < cur_word_q)) begin
						rp_next = rp_q + 1'b1;
					end else begin
						res.merged_word = cur_word_q;
						if (cur_fin_q && has_stored) begin
							state_next = ST_FLUSH;
						end else begin
							res.item_done  = 1'b1;
							res.merge_done = cur_fin_q;
							if (cur_fin_q) begin
								rp_next = '0;
								wc_next = '0;
							end
							state_next = ST_IDLE;
						end
					end
				end
			end
			ST_FLUSH: begin
				if (!has_stored) begin
					// nothing left to send: job ends without a result
					rp_next    = '0;
					wc_next    = '0;
					state_next = ST_IDLE;
				end else if (!res_full) begin
					res_push       = 1'b1;
					res.item_done  = last_stored;
					res.merge_done = last_stored;
					rp_next        = rp_q + 1'b1;
					if (last_stored) begin
						rp_next    = '0;
						wc_next    = '0;
						state_next = ST_IDLE;
					end
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_cur) begin
			cur_word_q <= cmd.word;
			cur_fin_q  <= cmd.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rp_q    <= '0;
			wc_q    <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_next;
			rp_q    <= rp_next;
			wc_q    <= wc_next;
			ovf_q   <= ovf_next;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/two_run_merge_core.sv
`default_nettype none
// two-way merge of two runs of 64-bit unsigned words, the merge step of merge
// sort. first-run words are kept in an on-chip store of FIRST_RUN_DEPTH
// entries; each second-run word releases, oldest first, every stored word
// strictly smaller than itself and then goes out itself (on a tie the
// second-run word wins). the item flagged final_item flushes what is left in
// the store and ends the job; the store starts empty for the next job. a
// first-run word that finds the store full is discarded and the sticky
// dropped flag rises on every later result until reset. both sides behave as
// queues: a transfer in happens when push is high and full is low, a transfer
// out when pop is high and empty is low. a two-entry command queue sits in
// front of the merge sequencer and a two-entry result queue behind it, so input
// keeps flowing while results wait. the sequencer takes each item in one step,
// then makes one step for every result word it produces (released stored
// words, the second-run word, flushed words) and holds while the result queue
// is full; a final first-run word that is dropped with nothing left to flush
// takes a step that sends nothing. a result is registered in the result queue
// before it shows on the ports. throughput is set by the sequencer, which sends
// at most one word a cycle and reads the store at one address a cycle.
module two_run_merge_core #(
	parameter int FIRST_RUN_DEPTH = trm_pkg::FIRST_RUN_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// input queue side
	input  wire logic            push,
	output logic                 full,
	input  wire trm_pkg::item_t  item,
	// result queue side
	input  wire logic            pop,
	output logic                 empty,
	output trm_pkg::result_t     result
);

	// front to back command path
	logic             cmd_empty;
	logic             cmd_pop;
	trm_pkg::cmd_t    cmd;

	// back to result queue path
	logic             res_full;
	logic             res_push;
	trm_pkg::result_t res;

	// front: takes each transfer in and tags it as store or merge
	trm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_pop  (cmd_pop),
		.cmd_empty(cmd_empty),
		.cmd      (cmd)
	);

	// back: first-run store plus the merge and flush sequencer
	trm_back #(
		.FIRST_RUN_DEPTH(FIRST_RUN_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// result queue decouples the sequencer from the consumer
	trm_fifo #(
		.T     (trm_pkg::result_t),
		.DEPTH (trm_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.din   (res),
		.pop   (pop),
		.empty (empty),
		.dout  (result)
	);

endmodule
`default_nettype wire

FILE: rtl/trm_checker.sv
`default_nettype none
module trm_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             full,
	input wire logic             pop,
	input wire logic             empty,
	input wire trm_pkg::result_t result
);

	// no result can be waiting and input is open right after reset
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> (empty && !full))
		else $error("result present or input blocked right after reset");

	// the overflow flag never clears once seen
	a_dropped_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.dropped) |=> (empty || result.dropped))
		else $error("dropped flag cleared");

	// end of merge is always the end of an item
	a_done_nesting: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.merge_done) |-> result.item_done)
		else $error("merge_done without item_done");

	// a waiting result holds until its transfer
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

endmodule

bind two_run_merge_core trm_checker u_trm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.full  (full),
	.pop   (pop),
	.empty (empty),
	.result(result)
);
`default_nettype wire
